/* hdl/qoi_pkg.sv */
// Shared types and constants for the quaternion orientation integrator.
`default_nettype none

package qoi_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;
    localparam logic [31:0] TIME_STEP_RESET = 32'd17895697;
    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

    // Width of a rate increment component (three Q.30 terms of up to 2^46).
    localparam int DW = 51;
    // Width of the sum before renormalising.
    localparam int SW = DW + 1;
    // Bits of the square root and of each quotient.
    localparam int RW = 31;

    typedef struct packed {
        logic signed [31:0] in_w;
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
        logic signed [31:0] rate_x;
        logic signed [31:0] rate_y;
        logic signed [31:0] rate_z;
    } item_t;

    typedef struct packed {
        logic signed [31:0] out_w;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               degenerate;
    } result_t;

    // Orientation and its rate term (0, omega) * q, as queued to the back end.
    typedef struct packed {
        logic [3:0][31:0]   q;
        logic [3:0][DW-1:0] d;
    } delta_t;

endpackage

`default_nettype wire

/* hdl/qoi_front.sv */
// Front end: takes requests and forms the Hamilton product terms.
`default_nettype none

module qoi_front
    import qoi_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    localparam int UW = $clog2(DEPTH + 1)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    output logic               item_stall,
    input  wire item_t         item,
    input  wire logic [UW-1:0] queue_used,
    output logic               push,
    output delta_t             push_data
);

    logic               v1_reg, v2_reg, v3_reg;
    item_t              it1_reg;
    logic [11:0][63:0]  p2_reg;
    logic [11:0][63:0]  p2_next;
    logic [3:0][31:0]   q2_reg;
    delta_t             d3_reg;
    delta_t             d3_next;
    logic [UW+1:0]      occ;
    logic               accept;
    logic [11:0][47:0]  rnd;
    logic [11:0][DW-1:0] rx;

    // Credit check: queued plus in flight must leave room for one more.
    assign occ = (UW+2)'(queue_used) + (UW+2)'(v1_reg) + (UW+2)'(v2_reg)
               + (UW+2)'(v3_reg);
    assign item_stall = (occ >= (UW+2)'(DEPTH));
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        p2_next[0]  = 64'(it1_reg.rate_x) * 64'(it1_reg.in_x);
        p2_next[1]  = 64'(it1_reg.rate_y) * 64'(it1_reg.in_y);
        p2_next[2]  = 64'(it1_reg.rate_z) * 64'(it1_reg.in_z);
        p2_next[3]  = 64'(it1_reg.rate_x) * 64'(it1_reg.in_w);
        p2_next[4]  = 64'(it1_reg.rate_y) * 64'(it1_reg.in_z);
        p2_next[5]  = 64'(it1_reg.rate_z) * 64'(it1_reg.in_y);
        p2_next[6]  = 64'(it1_reg.rate_y) * 64'(it1_reg.in_w);
        p2_next[7]  = 64'(it1_reg.rate_z) * 64'(it1_reg.in_x);
        p2_next[8]  = 64'(it1_reg.rate_x) * 64'(it1_reg.in_z);
        p2_next[9]  = 64'(it1_reg.rate_z) * 64'(it1_reg.in_w);
        p2_next[10] = 64'(it1_reg.rate_x) * 64'(it1_reg.in_y);
        p2_next[11] = 64'(it1_reg.rate_y) * 64'(it1_reg.in_x);
    end

    always_comb
    begin
        for (int k = 0; k < 12; k++)
        begin
            // round to Q.30: floor((p + 2^15) / 2^16)
            rnd[k] = 48'(($signed(p2_reg[k]) + 64'sd32768) >>> 16);
            // widen before summing: three terms can exceed 48 bits
            rx[k]  = DW'($signed(rnd[k]));
        end
        d3_next.q = q2_reg;
        d3_next.d[0] = DW'(-($signed(rx[0]) + $signed(rx[1]) + $signed(rx[2])));
        d3_next.d[1] = DW'($signed(rx[3]) + $signed(rx[4]) - $signed(rx[5]));
        d3_next.d[2] = DW'($signed(rx[6]) + $signed(rx[7]) - $signed(rx[8]));
        d3_next.d[3] = DW'($signed(rx[9]) + $signed(rx[10]) - $signed(rx[11]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            it1_reg <= item;
        end
        p2_reg    <= p2_next;
        q2_reg[0] <= it1_reg.in_w;
        q2_reg[1] <= it1_reg.in_x;
        q2_reg[2] <= it1_reg.in_y;
        q2_reg[3] <= it1_reg.in_z;
        d3_reg    <= d3_next;
    end

    assign push      = v3_reg;
    assign push_data = d3_reg;

endmodule

`default_nettype wire

/* hdl/qoi_queue.sv */
// Short queue between the front and back ends.
`default_nettype none

module qoi_queue
    import qoi_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    localparam int UW = $clog2(DEPTH + 1),
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire delta_t        push_data,
    input  wire logic          pop,
    output delta_t             pop_data,
    output logic [UW-1:0]      used
);

    delta_t        mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [UW-1:0] used_reg, used_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        used_next = used_reg + UW'(push) - UW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            used_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            used_reg   <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = mem_reg[rd_ptr_reg];
    assign used     = used_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> used_reg < UW'(DEPTH))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> used_reg != '0)
        else $error("queue pop while empty");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= UW'(DEPTH))
        else $error("queue count out of range");

endmodule

`default_nettype wire

/* hdl/qoi_back.sv */
// Back end: time-step increment, renormalising square root and divides.
`default_nettype none

module qoi_back
    import qoi_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    localparam int UW = $clog2(DEPTH + 1)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [31:0]   time_step,
    input  wire logic [UW-1:0] queue_used,
    input  wire delta_t        pop_data,
    output logic               pop,
    output logic               result_valid,
    input  wire logic          result_stall,
    output result_t            result
);

    // stages: 10 arithmetic, RW root, 1 setup, RW divide, 1 output
    localparam int NV = 10 + RW + 1 + RW + 1;

    typedef struct packed {
        logic [61:0]      n;
        logic [32:0]      rem;
        logic [RW-1:0]    root;
        logic [3:0][29:0] nm;
        logic [3:0]       sgn;
        logic             degen;
    } sq_t;

    typedef struct packed {
        logic [RW-1:0]        root;
        logic [3:0][RW-1:0]   rem;
        logic [3:0][RW-1:0]   quo;
        logic [3:0][RW-1:0]   low;
        logic [3:0]           sgn;
        logic                 degen;
    } dv_t;

    logic            adv;
    logic [NV-1:0]   vld_reg;

    logic [3:0][31:0]   q1_reg, q2_reg, q3_reg, q4_reg;
    logic [3:0][DW-1:0] d1_reg;
    logic [3:0][DW-1:0] mag2_reg, mag2_next;
    logic [3:0]         neg2_reg, neg2_next, neg3_reg, neg4_reg;
    logic [3:0][DW-1:0] a3_reg, a3_next;
    logic [3:0][63:0]   b3_reg, b3_next;
    logic [3:0][DW-1:0] c4_reg, c4_next;
    logic [3:0][SW-1:0] s5_reg, s5_next;
    logic [3:0][SW-1:0] mag6_reg, mag6_next, mag7_reg;
    logic [3:0]         sgn6_reg, sgn6_next, sgn7_reg, sgn8_reg, sgn9_reg;
    logic               right7_reg, right7_next;
    logic [5:0]         amt7_reg, amt7_next;
    logic               degen7_reg, degen7_next, degen8_reg, degen9_reg;
    logic [3:0][29:0]   nm8_reg, nm8_next, nm9_reg;
    logic [3:0][59:0]   sq9_reg, sq9_next;
    logic [SW-1:0]      orall;
    logic [5:0]         top;

    sq_t     sq_reg [RW+1];
    sq_t     sq_head_next;
    dv_t     dv_reg [RW+1];
    dv_t     dv_head_next;
    result_t out_reg, out_next;

    assign adv = !(vld_reg[NV-1] && result_stall);
    assign pop = adv && (queue_used != '0);

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            neg2_next[i] = d1_reg[i][DW-1];
            mag2_next[i] = d1_reg[i][DW-1] ? DW'(-$signed(d1_reg[i])) : d1_reg[i];
            a3_next[i] = DW'(64'(mag2_reg[i][DW-1:32]) * 64'(time_step));
            b3_next[i] = 64'(mag2_reg[i][31:0]) * 64'(time_step);
            // half of d * dt / 2^32, rounded half away from zero on magnitude
            c4_next[i] = DW'((64'(a3_reg[i]) + 64'(b3_reg[i][63:32]) + 64'd1) >> 1);
            s5_next[i] = neg4_reg[i]
                ? SW'($signed(q4_reg[i])) - $signed({1'b0, c4_reg[i]})
                : SW'($signed(q4_reg[i])) + $signed({1'b0, c4_reg[i]});
            sgn6_next[i] = s5_reg[i][SW-1];
            mag6_next[i] = s5_reg[i][SW-1] ? SW'(-$signed(s5_reg[i])) : s5_reg[i];
            nm8_next[i]  = right7_reg ? 30'(mag7_reg[i] >> amt7_reg)
                                      : 30'(mag7_reg[i] << amt7_reg);
            sq9_next[i]  = 60'(nm8_reg[i]) * 60'(nm8_reg[i]);
        end
    end

    // leading one of the largest magnitude sets the common shift
    always_comb
    begin
        orall = mag6_reg[0] | mag6_reg[1] | mag6_reg[2] | mag6_reg[3];
        top = '0;
        for (int b = 0; b < SW; b++)
        begin
            if (orall[b])
            begin
                top = 6'(b);
            end
        end
        degen7_next = (orall == '0);
        right7_next = (top >= 6'd29);
        amt7_next   = right7_next ? top - 6'd29 : 6'd29 - top;
    end

    always_comb
    begin
        sq_head_next.n     = 62'(sq9_reg[0]) + 62'(sq9_reg[1])
                           + 62'(sq9_reg[2]) + 62'(sq9_reg[3]);
        sq_head_next.rem   = '0;
        sq_head_next.root  = '0;
        sq_head_next.nm    = nm9_reg;
        sq_head_next.sgn   = sgn9_reg;
        sq_head_next.degen = degen9_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q1_reg     <= pop_data.q;
            d1_reg     <= pop_data.d;
            q2_reg     <= q1_reg;
            mag2_reg   <= mag2_next;
            neg2_reg   <= neg2_next;
            q3_reg     <= q2_reg;
            a3_reg     <= a3_next;
            b3_reg     <= b3_next;
            neg3_reg   <= neg2_reg;
            q4_reg     <= q3_reg;
            c4_reg     <= c4_next;
            neg4_reg   <= neg3_reg;
            s5_reg     <= s5_next;
            mag6_reg   <= mag6_next;
            sgn6_reg   <= sgn6_next;
            mag7_reg   <= mag6_reg;
            sgn7_reg   <= sgn6_reg;
            right7_reg <= right7_next;
            amt7_reg   <= amt7_next;
            degen7_reg <= degen7_next;
            nm8_reg    <= nm8_next;
            sgn8_reg   <= sgn7_reg;
            degen8_reg <= degen7_reg;
            sq9_reg    <= sq9_next;
            nm9_reg    <= nm8_reg;
            sgn9_reg   <= sgn8_reg;
            degen9_reg <= degen8_reg;
            sq_reg[0]  <= sq_head_next;
        end
    end

    // square root, one result bit per stage
    for (genvar j = 0; j < RW; j++)
    begin : g_root
        sq_t sq_step_next;

        always_comb
        begin
            logic [34:0] cur;
            logic [34:0] trial;
            cur   = {sq_reg[j].rem, sq_reg[j].n[61-2*j -: 2]};
            trial = {2'b00, sq_reg[j].root, 2'b01};
            sq_step_next = sq_reg[j];
            if (cur >= trial)
            begin
                sq_step_next.rem  = 33'(cur - trial);
                sq_step_next.root = {sq_reg[j].root[RW-2:0], 1'b1};
            end
            else
            begin
                sq_step_next.rem  = cur[32:0];
                sq_step_next.root = {sq_reg[j].root[RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_reg[j+1] <= sq_step_next;
            end
        end
    end

    // numerator is (mag << 30) + root/2; mag <= root so the quotient fits RW bits
    always_comb
    begin
        dv_head_next.root  = sq_reg[RW].root;
        dv_head_next.sgn   = sq_reg[RW].sgn;
        dv_head_next.degen = sq_reg[RW].degen;
        for (int i = 0; i < 4; i++)
        begin
            dv_head_next.rem[i] = RW'(sq_reg[RW].nm[i] >> 1);
            dv_head_next.quo[i] = '0;
            dv_head_next.low[i] = {sq_reg[RW].nm[i][0], sq_reg[RW].root[RW-1:1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_reg[0] <= dv_head_next;
        end
    end

    for (genvar k = 0; k < RW; k++)
    begin : g_div
        dv_t dv_step_next;

        always_comb
        begin
            logic [RW:0] cur;
            dv_step_next = dv_reg[k];
            for (int i = 0; i < 4; i++)
            begin
                cur = {dv_reg[k].rem[i], dv_reg[k].low[i][RW-1-k]};
                if (cur >= {1'b0, dv_reg[k].root})
                begin
                    dv_step_next.rem[i] = RW'(cur - {1'b0, dv_reg[k].root});
                    dv_step_next.quo[i] = {dv_reg[k].quo[i][RW-2:0], 1'b1};
                end
                else
                begin
                    dv_step_next.rem[i] = cur[RW-1:0];
                    dv_step_next.quo[i] = {dv_reg[k].quo[i][RW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_reg[k+1] <= dv_step_next;
            end
        end
    end

    always_comb
    begin
        logic [3:0][31:0] v;
        for (int i = 0; i < 4; i++)
        begin
            v[i] = dv_reg[RW].sgn[i] ? 32'(-$signed({1'b0, dv_reg[RW].quo[i]}))
                                     : {1'b0, dv_reg[RW].quo[i]};
        end
        if (dv_reg[RW].degen)
        begin
            out_next.out_w      = ONE_Q30;
            out_next.out_x      = '0;
            out_next.out_y      = '0;
            out_next.out_z      = '0;
            out_next.degenerate = 1'b1;
        end
        else
        begin
            out_next.out_w      = v[0];
            out_next.out_x      = v[1];
            out_next.out_y      = v[2];
            out_next.out_z      = v[3];
            out_next.degenerate = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NV-2:0], pop};
        end
    end

    assign result_valid = vld_reg[NV-1];
    assign result       = out_reg;

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> queue_used != '0)
        else $error("pop from empty queue");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");

    a_unit: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NV-1] && !out_reg.degenerate |->
            $signed(out_reg.out_w) <= $signed(ONE_Q30) &&
            $signed(out_reg.out_w) >= -$signed(ONE_Q30))
        else $error("normalised component above one");

    a_identity: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NV-1] && out_reg.degenerate |->
            out_reg.out_w == ONE_Q30 && out_reg.out_x == '0 &&
            out_reg.out_y == '0 && out_reg.out_z == '0)
        else $error("degenerate result is not the identity");

endmodule

`default_nettype wire

/* hdl/quaternion_orientation_integrate.sv */
// Top level of the quaternion orientation integrator.
//
//   channel  direction  handshake                 payload
//   item     in         item_valid / item_stall   item_t
//   result   out        result_valid / result_stall  result_t
//   cfg      in         cfg_valid / cfg_ready     cfg_data (time_step)
//
// One request per cycle sustained while result_stall is low; requests pass
// the front-end registers and the queue, then 74 back-end stages, dominated
// by the bit-per-stage square root and the four bit-per-stage dividers.
// Reset sets time_step to about 1/240 s and empties queue and pipelines.
// A stalled result freezes the back end; the queue keeps taking requests
// until its credit runs out, then item_stall rises.
`default_nettype none

module quaternion_orientation_integrate
    import qoi_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    output logic         item_stall,
    input  wire item_t   item,
    output logic         result_valid,
    input  wire logic    result_stall,
    output result_t      result,
    input  wire logic    cfg_valid,
    output logic         cfg_ready,
    input  wire logic [31:0] cfg_data
);

    localparam int UW = $clog2(QUEUE_DEPTH + 1);

    logic [31:0]   time_step_reg;
    logic          push, pop;
    delta_t        push_data, pop_data;
    logic [UW-1:0] queue_used;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg <= TIME_STEP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            time_step_reg <= cfg_data;
        end
    end

    qoi_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .queue_used (queue_used),
        .push       (push),
        .push_data  (push_data)
    );

    qoi_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .used      (queue_used)
    );

    qoi_back #(.DEPTH(QUEUE_DEPTH)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .time_step    (time_step_reg),
        .queue_used   (queue_used),
        .pop_data     (pop_data),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire
